[design/tmaf_pkg.sv]
`timescale 1ns / 1ps

package tmaf_pkg;

  localparam int unsigned CODE_W = 13;
  localparam int unsigned MV_W   = 14;

  // Millivolt scaling: code * ADC_REF / ADC_FULL * MV_NUM / MV_DEN
  localparam int unsigned ADC_REF  = 2563;
  localparam int unsigned ADC_FULL = 8191;
  localparam int unsigned MV_NUM   = 321;
  localparam int unsigned MV_DEN   = 51;
  localparam logic [MV_W-1:0] MV_MAX = 14'd16383;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_WALK,
    OP_TRIM,
    OP_RECIP,
    OP_BACK,
    OP_FIX,
    OP_SCALE,
    OP_LOAD
  } op_t;

  // Which constant divide is in flight
  typedef enum logic [1:0] {
    DIV_WIN,
    DIV_ADC,
    DIV_MV
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    div_sel_t dsel;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
    logic out_busy;
  } stat_t;

endpackage

[design/trimmed_mean_adc_filter.sv]
`timescale 1ns / 1ps
// Channel | Ports              | Beat contents
// input   | in_tvalid/tready   | in_tdata[12:0] sample
// result  | out_tvalid/tready  | out_tdata[12:0] filtered_code, [26:13] voltage_mv
//
// For one item, the window walk reads one stored sample per cycle, then three
// constant divides each run a reciprocal multiply, a back-multiply and a fix
// step, sharing one multiplier, with one scale step between them.
// rst_n is synchronous; it clears the sample window, the write slot and control.
// A finished result waits in the output register; a stall there holds only the
// final load step, the next input beat is taken as soon as the load is done.
module trimmed_mean_adc_filter #(
  parameter int WINDOW_LEN  = 10,
  parameter int SAMPLE_BITS = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [12:0] sample, [15:13] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [12:0] filtered_code, [26:13] voltage_mv, [31:27] zero
);

  tmaf_pkg::cmd_t  cmd;
  tmaf_pkg::stat_t stat;
  logic [tmaf_pkg::CODE_W-1:0] out_code;
  logic [tmaf_pkg::MV_W-1:0]   out_mv;

  tmaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmaf_dp #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_sample  (in_tdata[tmaf_pkg::CODE_W-1:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_code   (out_code),
    .out_mv     (out_mv)
  );

  assign out_tdata = {5'b0, out_mv, out_code};

endmodule

[design/tmaf_ctrl.sv]
`timescale 1ns / 1ps

module tmaf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  tmaf_pkg::stat_t  stat,
  output tmaf_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_TRIM,
    S_RECIP,
    S_BACK,
    S_FIX,
    S_SCALE,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  tmaf_pkg::div_sel_t dsel_r, dsel_nxt;
  logic               rdy_r, rdy_nxt;

  assign in_tready = rdy_r;

  always_comb begin
    state_nxt = state_r;
    dsel_nxt  = dsel_r;
    rdy_nxt   = rdy_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && rdy_r) begin
          state_nxt = S_WALK;
          dsel_nxt  = tmaf_pkg::DIV_WIN;
          rdy_nxt   = 1'b0;
        end
      end
      S_WALK: begin
        if (stat.walk_last) begin
          state_nxt = S_TRIM;
        end
      end
      S_TRIM:  state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_BACK;
      S_BACK:  state_nxt = S_FIX;
      S_FIX: begin
        case (dsel_r)
          tmaf_pkg::DIV_WIN: begin
            state_nxt = S_SCALE;
            dsel_nxt  = tmaf_pkg::DIV_ADC;
          end
          tmaf_pkg::DIV_ADC: begin
            state_nxt = S_SCALE;
            dsel_nxt  = tmaf_pkg::DIV_MV;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SCALE: state_nxt = S_RECIP;
      S_OUT: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
          rdy_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        rdy_nxt   = 1'b1;
      end
    endcase
  end

  always_comb begin
    cmd.dsel = dsel_r;
    case (state_r)
      S_IDLE:  cmd.op = (in_tvalid && rdy_r) ? tmaf_pkg::OP_WRITE : tmaf_pkg::OP_NONE;
      S_WALK:  cmd.op = tmaf_pkg::OP_WALK;
      S_TRIM:  cmd.op = tmaf_pkg::OP_TRIM;
      S_RECIP: cmd.op = tmaf_pkg::OP_RECIP;
      S_BACK:  cmd.op = tmaf_pkg::OP_BACK;
      S_FIX:   cmd.op = tmaf_pkg::OP_FIX;
      S_SCALE: cmd.op = tmaf_pkg::OP_SCALE;
      S_OUT:   cmd.op = stat.out_busy ? tmaf_pkg::OP_NONE : tmaf_pkg::OP_LOAD;
      default: cmd.op = tmaf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dsel_r  <= tmaf_pkg::DIV_WIN;
      rdy_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      dsel_r  <= dsel_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

endmodule

[design/tmaf_dp.sv]
`timescale 1ns / 1ps

module tmaf_dp #(
  parameter int WINDOW_LEN  = 10,
  parameter int SAMPLE_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tmaf_pkg::cmd_t               cmd,
  output tmaf_pkg::stat_t              stat,
  input  logic [tmaf_pkg::CODE_W-1:0]  in_sample,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [tmaf_pkg::CODE_W-1:0]  out_code,
  output logic [tmaf_pkg::MV_W-1:0]    out_mv
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int MEAN_W = SAMPLE_BITS;
  // widest dividend: mean * ADC_REF
  localparam int X_W    = SAMPLE_BITS + 12;
  localparam int R_W    = X_W + 1;
  localparam int P_W    = X_W + R_W;

  localparam longint unsigned SCALE_ONE = 64'd1 << X_W;
  localparam logic [R_W-1:0] RECIP_WIN = R_W'(SCALE_ONE / (WINDOW_LEN - 2));
  localparam logic [R_W-1:0] RECIP_ADC = R_W'(SCALE_ONE / tmaf_pkg::ADC_FULL);
  localparam logic [R_W-1:0] RECIP_MV  = R_W'(SCALE_ONE / tmaf_pkg::MV_DEN);

  logic [SAMPLE_BITS-1:0] win_r [WINDOW_LEN];
  logic [SLOT_W-1:0]      wr_slot_r;
  logic [SLOT_W-1:0]      rd_idx_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] hi_r, lo_r;
  logic [X_W-1:0]         x_r, q_r;
  logic [P_W-1:0]         prod_r;
  logic [MEAN_W-1:0]      mean_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [tmaf_pkg::CODE_W-1:0]  out_code_r;
  logic [tmaf_pkg::MV_W-1:0]    out_mv_r;

  logic [tmaf_pkg::CODE_W+SAMPLE_BITS-1:0] sample_ext;
  logic [SAMPLE_BITS-1:0]  sample_s;
  logic [SLOT_W-1:0]       slot_use;
  logic [SAMPLE_BITS-1:0]  rd_val;
  logic [SUM_W-1:0]        trim_diff;
  logic [X_W-1:0]          d_val;
  logic [R_W-1:0]          recip_val, k_val;
  logic [X_W-1:0]          mul_a, q_est, rem;
  logic [R_W-1:0]          mul_b;
  logic [P_W-1:0]          mul_p;
  logic [MEAN_W+tmaf_pkg::CODE_W-1:0] code_ext;
  logic [tmaf_pkg::MV_W-1:0] mv_sat;

  assign sample_ext = {{SAMPLE_BITS{1'b0}}, in_sample};
  assign sample_s   = sample_ext[SAMPLE_BITS-1:0];
  assign slot_use   = ({1'b0, wr_slot_r} >= (SLOT_W+1)'(WINDOW_LEN)) ? '0 : wr_slot_r;
  assign rd_val     = win_r[rd_idx_r];
  assign trim_diff  = sum_r - SUM_W'(hi_r) - SUM_W'(lo_r);
  assign q_est      = prod_r[X_W +: X_W];
  assign rem        = x_r - prod_r[X_W-1:0];
  assign code_ext   = {{tmaf_pkg::CODE_W{1'b0}}, mean_r};
  assign mv_sat     = (q_r > X_W'(tmaf_pkg::MV_MAX)) ? tmaf_pkg::MV_MAX
                                                     : q_r[tmaf_pkg::MV_W-1:0];

  always_comb begin
    case (cmd.dsel)
      tmaf_pkg::DIV_WIN: begin
        d_val     = X_W'(WINDOW_LEN - 2);
        recip_val = RECIP_WIN;
        k_val     = '0;
      end
      tmaf_pkg::DIV_ADC: begin
        d_val     = X_W'(tmaf_pkg::ADC_FULL);
        recip_val = RECIP_ADC;
        k_val     = R_W'(tmaf_pkg::ADC_REF);
      end
      tmaf_pkg::DIV_MV: begin
        d_val     = X_W'(tmaf_pkg::MV_DEN);
        recip_val = RECIP_MV;
        k_val     = R_W'(tmaf_pkg::MV_NUM);
      end
      default: begin
        d_val     = X_W'(1);
        recip_val = '0;
        k_val     = '0;
      end
    endcase
  end

  // one shared multiplier: reciprocal estimate, back-multiply, scale
  always_comb begin
    case (cmd.op)
      tmaf_pkg::OP_RECIP: begin
        mul_a = x_r;
        mul_b = recip_val;
      end
      tmaf_pkg::OP_BACK: begin
        mul_a = q_est;
        mul_b = {1'b0, d_val};
      end
      tmaf_pkg::OP_SCALE: begin
        mul_a = q_r;
        mul_b = k_val;
      end
      default: begin
        mul_a = x_r;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == tmaf_pkg::OP_LOAD) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        win_r[k] <= '0;
      end
      wr_slot_r   <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (cmd.op)
        tmaf_pkg::OP_WRITE: begin
          win_r[slot_use] <= sample_s;
          wr_slot_r <= (slot_use == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_use + 1'b1;
          rd_idx_r  <= '0;
        end
        tmaf_pkg::OP_WALK: begin
          rd_idx_r <= (rd_idx_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : rd_idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tmaf_pkg::OP_WALK: begin
        if (rd_idx_r == '0) begin
          sum_r <= SUM_W'(rd_val);
          hi_r  <= rd_val;
          lo_r  <= rd_val;
        end else begin
          sum_r <= sum_r + SUM_W'(rd_val);
          if (rd_val > hi_r) hi_r <= rd_val;
          if (rd_val < lo_r) lo_r <= rd_val;
        end
      end
      tmaf_pkg::OP_TRIM:  x_r <= X_W'(trim_diff);
      tmaf_pkg::OP_RECIP: prod_r <= mul_p;
      tmaf_pkg::OP_BACK: begin
        q_r    <= q_est;
        prod_r <= mul_p;
      end
      // estimate is at most one low
      tmaf_pkg::OP_FIX:   q_r <= q_r + X_W'(rem >= d_val);
      tmaf_pkg::OP_SCALE: begin
        x_r <= mul_p[X_W-1:0];
        if (cmd.dsel == tmaf_pkg::DIV_ADC) mean_r <= q_r[MEAN_W-1:0];
      end
      tmaf_pkg::OP_LOAD: begin
        out_code_r <= code_ext[tmaf_pkg::CODE_W-1:0];
        out_mv_r   <= mv_sat;
      end
      default: ;
    endcase
  end

  assign stat.walk_last = (rd_idx_r == SLOT_W'(WINDOW_LEN - 1));
  assign stat.out_busy  = out_valid_r && !out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_code       = out_code_r;
  assign out_mv         = out_mv_r;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, wr_slot_r} < (SLOT_W+1)'(WINDOW_LEN))
    else $error("write slot out of range");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, rd_idx_r} < (SLOT_W+1)'(WINDOW_LEN))
    else $error("walk index out of range");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tmaf_pkg::OP_WALK && stat.walk_last) |=> (hi_r >= lo_r))
    else $error("window max below min after walk");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tmaf_pkg::OP_LOAD) |-> !(out_valid_r && !out_tready))
    else $error("result loaded over a stalled beat");
`endif

endmodule
